// ===== src/npcm_pkg.sv =====
//------------------------------------------------------------------------------
// Nearest palette color match: shared definitions
// Constants, action codes and the sequencer state type that are used by the
// nearest palette color match block and its distance unit.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package npcm_pkg;

    // Default palette depth and fixed field widths.
    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int CHAN_W              = 8;
    localparam int COLOR_W             = 3 * CHAN_W;
    localparam int COUNT_W             = 9;
    localparam int DIST_W              = 18;

    // Reset value of the target count register.
    localparam logic [COUNT_W-1:0] TARGET_COUNT_RESET = 9'd256;

    // Action codes carried in the input tuser field.
    localparam logic [1:0] ACT_LOAD_SRC = 2'd0;
    localparam logic [1:0] ACT_LOAD_TGT = 2'd1;
    localparam logic [1:0] ACT_MAP      = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SEARCH,
        ST_DRAIN
    } npcm_state_t;

endpackage

`default_nettype wire

// ===== src/npcm_dist.sv =====
//------------------------------------------------------------------------------
// Nearest palette color match: color distance unit
// Computes the sum of squared red, green and blue differences of two colors
// and registers it together with a valid flag and the target entry index.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module npcm_dist #(
    parameter int IDX_W = $clog2(npcm_pkg::PALETTE_ENTRIES_DEF)
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        in_valid,
    input  wire  [IDX_W-1:0]           in_index,
    input  wire  [npcm_pkg::COLOR_W-1:0] color_a,
    input  wire  [npcm_pkg::COLOR_W-1:0] color_b,
    output logic                       out_valid,
    output logic [IDX_W-1:0]           out_index,
    output logic [npcm_pkg::DIST_W-1:0] out_dist
);

    logic [npcm_pkg::CHAN_W-1:0]   diff [3];
    logic [2*npcm_pkg::CHAN_W-1:0] sq   [3];
    logic [npcm_pkg::DIST_W-1:0]   dist_sum;
    logic                          valid_reg;
    logic [IDX_W-1:0]              index_reg;
    logic [npcm_pkg::DIST_W-1:0]   dist_reg;

    // Absolute channel differences, squared, then summed.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (color_a[c*npcm_pkg::CHAN_W +: npcm_pkg::CHAN_W] >
                color_b[c*npcm_pkg::CHAN_W +: npcm_pkg::CHAN_W]) begin
                diff[c] = color_a[c*npcm_pkg::CHAN_W +: npcm_pkg::CHAN_W] -
                          color_b[c*npcm_pkg::CHAN_W +: npcm_pkg::CHAN_W];
            end else begin
                diff[c] = color_b[c*npcm_pkg::CHAN_W +: npcm_pkg::CHAN_W] -
                          color_a[c*npcm_pkg::CHAN_W +: npcm_pkg::CHAN_W];
            end
            sq[c] = (2*npcm_pkg::CHAN_W)'(diff[c]) * (2*npcm_pkg::CHAN_W)'(diff[c]);
        end
        dist_sum = npcm_pkg::DIST_W'(sq[0]) + npcm_pkg::DIST_W'(sq[1]) +
                   npcm_pkg::DIST_W'(sq[2]);
    end

    // Result register; only the valid flag is reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
        index_reg <= in_index;
        dist_reg  <= dist_sum;
    end

    assign out_valid = valid_reg;
    assign out_index = index_reg;
    assign out_dist  = dist_reg;

endmodule

`default_nettype wire

// ===== src/nearest_palette_color_match.sv =====
//------------------------------------------------------------------------------
// Nearest palette color match
// Maps indexed pixels from a source palette to the nearest target palette
// entry, with a per-pixel cache of earlier matches.
//------------------------------------------------------------------------------
// Usage:
// The s_ channel carries one action per transfer (tuser): load a source entry,
// load a target entry, or map a pixel. Loads give no result; a load whose
// entry is in range clears the match cache. A map gives one result transfer
// on the m_ channel: the target index, a matched flag and a cache-hit flag.
// A pixel that is out of range, meets an empty target palette or hits the
// cache is answered from the lookup state. A miss searches the target
// palette one entry per cycle through the distance unit, over target_count
// entries (saturated to the palette depth), and is answered once the
// distance unit has drained and the output register is free.
// s_tready is low while a map is in progress. A finished result sits in the
// output register, so a following load is taken while the receiver stalls;
// a second result waits in the sequencer until the register frees up.
// cfg_wen writes target_count (saturated to the palette depth where it is
// used) and clears the cache; the user must use it only while the block is
// idle, and the block itself does not enforce this.
// aresetn (synchronous, active low) invalidates the cache, sets target_count
// to 256 and empties the output; palette contents are not cleared.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nearest_palette_color_match #(
    parameter int PALETTE_ENTRIES = npcm_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    // Configuration: target_count
    input  wire         cfg_wen,
    input  wire  [8:0]  cfg_wdata,
    // Input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    // entry_index[7:0], pixel_value[15:8], red[23:16], green[31:24], blue[39:32]
    input  wire  [39:0] s_tdata,
    // action[1:0]
    input  wire  [1:0]  s_tuser,
    // Result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    // mapped_index[7:0]
    output logic [7:0]  m_tdata,
    // matched[0], cache_hit[1]
    output logic [1:0]  m_tuser
);

    localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);
    localparam logic [8:0] DEPTH_9 = 9'(PALETTE_ENTRIES);

    // Input fields.
    logic [1:0]                    s_action;
    logic [7:0]                    s_entry;
    logic [7:0]                    s_pixel;
    logic [npcm_pkg::COLOR_W-1:0]  s_color;

    assign s_action = s_tuser;
    assign s_entry  = s_tdata[7:0];
    assign s_pixel  = s_tdata[15:8];
    assign s_color  = {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};

    // Sequencer and datapath registers.
    npcm_pkg::npcm_state_t        state_reg, state_next;
    logic [8:0]                   tc_reg;
    logic [PALETTE_ENTRIES-1:0]   valid_reg;
    logic [7:0]                   pix_reg;
    logic [CNT_W-1:0]             iss_reg;
    logic                         v1_reg;
    logic [IDX_W-1:0]             idx1_reg;
    logic [IDX_W-1:0]             best_reg;
    logic [npcm_pkg::DIST_W-1:0]  best_dist_reg;
    logic                         found_reg;
    logic [npcm_pkg::COLOR_W-1:0] src_rd_reg;
    logic [npcm_pkg::COLOR_W-1:0] tgt_rd_reg;
    logic [IDX_W-1:0]             cache_rd_reg;
    logic                         m_tvalid_reg;
    logic [7:0]                   m_tdata_reg;
    logic [1:0]                   m_tuser_reg;

    // Memories.
    logic [npcm_pkg::COLOR_W-1:0] src_mem   [PALETTE_ENTRIES];
    logic [npcm_pkg::COLOR_W-1:0] tgt_mem   [PALETTE_ENTRIES];
    logic [IDX_W-1:0]             cache_mem [PALETTE_ENTRIES];

    // Control decodes.
    logic                         accept;
    logic                         load_ok;
    logic [CNT_W-1:0]             eff_count;
    logic                         pix_in_range;
    logic                         pix_hit;
    logic                         out_free;
    logic                         last_issue;
    logic                         drain_done;
    logic                         dist_valid;
    logic [IDX_W-1:0]             dist_index;
    logic [npcm_pkg::DIST_W-1:0]  dist_value;

    // Sequencer outputs.
    logic                         issue_en;
    logic                         search_start;
    logic                         res_load;
    logic                         cache_wr;
    logic [7:0]                   res_index;
    logic                         res_matched;
    logic                         res_hit;

    assign accept       = s_tvalid && s_tready;
    assign load_ok      = accept && ((s_action == npcm_pkg::ACT_LOAD_SRC) ||
                                     (s_action == npcm_pkg::ACT_LOAD_TGT)) &&
                          ({1'b0, s_entry} < DEPTH_9);
    assign eff_count    = (tc_reg > DEPTH_9) ? CNT_W'(PALETTE_ENTRIES) : tc_reg[CNT_W-1:0];
    assign pix_in_range = ({1'b0, pix_reg} < DEPTH_9);
    assign pix_hit      = pix_in_range && valid_reg[pix_reg[IDX_W-1:0]];
    assign out_free     = !m_tvalid_reg || m_tready;
    assign last_issue   = (iss_reg == (eff_count - CNT_W'(1)));
    assign drain_done   = !v1_reg && !dist_valid;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            npcm_pkg::ST_IDLE: begin
                if (accept && (s_action == npcm_pkg::ACT_MAP)) begin
                    state_next = npcm_pkg::ST_LOOKUP;
                end
            end
            npcm_pkg::ST_LOOKUP: begin
                if (!pix_in_range || (eff_count == '0) || pix_hit) begin
                    if (out_free) begin
                        state_next = npcm_pkg::ST_IDLE;
                    end
                end else begin
                    state_next = npcm_pkg::ST_SEARCH;
                end
            end
            npcm_pkg::ST_SEARCH: begin
                if (last_issue) begin
                    state_next = npcm_pkg::ST_DRAIN;
                end
            end
            npcm_pkg::ST_DRAIN: begin
                if (drain_done && out_free) begin
                    state_next = npcm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = npcm_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready     = 1'b0;
        issue_en     = 1'b0;
        search_start = 1'b0;
        res_load     = 1'b0;
        cache_wr     = 1'b0;
        res_index    = pix_reg;
        res_matched  = 1'b0;
        res_hit      = 1'b0;
        case (state_reg)
            npcm_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            npcm_pkg::ST_LOOKUP: begin
                if (!pix_in_range || (eff_count == '0)) begin
                    res_load = out_free;
                end else if (pix_hit) begin
                    res_load    = out_free;
                    res_index   = 8'(cache_rd_reg);
                    res_matched = 1'b1;
                    res_hit     = 1'b1;
                end else begin
                    search_start = 1'b1;
                end
            end
            npcm_pkg::ST_SEARCH: begin
                issue_en = 1'b1;
            end
            npcm_pkg::ST_DRAIN: begin
                res_index   = 8'(best_reg);
                res_matched = 1'b1;
                if (drain_done && out_free) begin
                    res_load = 1'b1;
                    cache_wr = 1'b1;
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // State, configuration and cache valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= npcm_pkg::ST_IDLE;
            tc_reg    <= npcm_pkg::TARGET_COUNT_RESET;
            valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wen) begin
                tc_reg <= cfg_wdata;
            end
            if (cfg_wen || load_ok) begin
                valid_reg <= '0;
            end else if (cache_wr) begin
                valid_reg[pix_reg[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    // Source palette: written by loads, read once per mapped pixel.
    always_ff @(posedge aclk) begin
        if (load_ok && (s_action == npcm_pkg::ACT_LOAD_SRC)) begin
            src_mem[s_entry[IDX_W-1:0]] <= s_color;
        end
        if (accept) begin
            src_rd_reg <= src_mem[s_pixel[IDX_W-1:0]];
        end
    end

    // Target palette: written by loads, read by the search counter.
    always_ff @(posedge aclk) begin
        if (load_ok && (s_action == npcm_pkg::ACT_LOAD_TGT)) begin
            tgt_mem[s_entry[IDX_W-1:0]] <= s_color;
        end
        tgt_rd_reg <= tgt_mem[iss_reg[IDX_W-1:0]];
    end

    // Match cache data: written at the end of a search, read per pixel.
    always_ff @(posedge aclk) begin
        if (cache_wr) begin
            cache_mem[pix_reg[IDX_W-1:0]] <= best_reg;
        end
        if (accept) begin
            cache_rd_reg <= cache_mem[s_pixel[IDX_W-1:0]];
        end
    end

    // Search counter and read-stage tag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= issue_en;
        end
        if (search_start) begin
            iss_reg <= '0;
        end else if (issue_en) begin
            iss_reg <= iss_reg + CNT_W'(1);
        end
        idx1_reg <= iss_reg[IDX_W-1:0];
        if (accept) begin
            pix_reg <= s_pixel;
        end
    end

    npcm_dist #(
        .IDX_W (IDX_W)
    ) u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1_reg),
        .in_index  (idx1_reg),
        .color_a   (src_rd_reg),
        .color_b   (tgt_rd_reg),
        .out_valid (dist_valid),
        .out_index (dist_index),
        .out_dist  (dist_value)
    );

    // Best-match tracking; equal distance lets the later entry win.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (search_start) begin
            found_reg <= 1'b0;
        end else if (dist_valid) begin
            found_reg <= 1'b1;
        end
        if (dist_valid && (!found_reg || (dist_value <= best_dist_reg))) begin
            best_reg      <= dist_index;
            best_dist_reg <= dist_value;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (res_load) begin
            m_tdata_reg <= res_index;
            m_tuser_reg <= {res_hit, res_matched};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire
